// ===== src/interval_overlap_sweep_aggregator_assert.svh =====
// Assertion macros used by the checker file iosa_chk.
`ifndef INTERVAL_OVERLAP_SWEEP_AGGREGATOR_ASSERT_SVH
`define INTERVAL_OVERLAP_SWEEP_AGGREGATOR_ASSERT_SVH

// same-cycle implication
`define IOSA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IOSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/iosa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosa_pkg
// Types and fixed widths of the interval overlap sweep aggregator.
// ----------------------------------------------------------------------------
package iosa_pkg;

	localparam int TS_W  = 63;
	localparam int VAL_W = 32;
	localparam int SUM_W = 40;
	localparam int GRP_W = 6;
	localparam int ACT_W = 5;

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_SWEEP = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                    cmd;
		logic [TS_W-1:0]         interval_start;
		logic [TS_W-1:0]         interval_end;
		logic signed [VAL_W-1:0] interval_value;
		logic                    value_present;
	} in_req_t;

	typedef struct packed {
		logic                    bucket_valid;
		logic [TS_W-1:0]         bucket_start;
		logic [TS_W-1:0]         bucket_end;
		logic [GRP_W-1:0]        group_number;
		logic [ACT_W-1:0]        live_count;
		logic signed [SUM_W-1:0] value_sum;
		logic signed [VAL_W-1:0] value_min;
		logic signed [VAL_W-1:0] value_max;
		logic                    min_max_valid;
		logic signed [VAL_W-1:0] value_average;
		logic                    load_overflow;
		logic                    last;
	} out_rsp_t;

endpackage

// ===== src/interval_overlap_sweep_aggregator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_overlap_sweep_aggregator
// Loads intervals, then sweeps their start/end events and reports buckets.
// ----------------------------------------------------------------------------
// A load request stores one interval, or flags overflow when the store is full.
// A sweep request finds events in sorted order by rescanning the store: each
// event is found by passing all 2N stored starts and ends through one key
// comparator (N = intervals loaded). Each bucket adds aggregation over the N
// intervals through the shared accumulator, the serial divider for the average,
// and the output handshake. The done marker closes every sweep; the store is
// empty after it. The block takes no request while a sweep runs.
module interval_overlap_sweep_aggregator #(
	parameter int MAX_INTERVALS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  iosa_pkg::in_req_t  in_req,
	output logic               out_valid,
	input  logic               out_stall,
	output iosa_pkg::out_rsp_t out_rsp,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	localparam int TS_W  = iosa_pkg::TS_W;
	localparam int VAL_W = iosa_pkg::VAL_W;
	localparam int SUM_W = iosa_pkg::SUM_W;
	localparam int IW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW    = $clog2(MAX_INTERVALS + 1);
	localparam int EW    = CW + 1;
	localparam int KW    = TS_W + 1 + IW;
	localparam int RES_LIMIT = 3 * MAX_INTERVALS + 1;
	localparam int RW    = $clog2(RES_LIMIT);

	typedef enum logic [3:0] {
		S_IDLE, S_FIND, S_GAP, S_UPD, S_INST, S_AGG, S_DIV, S_OUT, S_NEXT, S_DONE
	} state_t;

	state_t                   state_q;
	logic                     en_q;
	logic [CW-1:0]            nload_q;
	logic                     ovf_q;
	logic [MAX_INTERVALS-1:0] active_q;
	logic [CW-1:0]            cnt_q;
	logic [TS_W-1:0]          prev_q;
	logic [iosa_pkg::GRP_W-1:0] grp_q;
	logic                     inst_q;
	logic [RW-1:0]            nres_q;
	logic [EW-1:0]            k_q;
	logic [IW-1:0]            a_q;
	logic [KW-1:0]            cur_key_q;
	logic                     have_cur_q;
	logic [KW-1:0]            best_key_q;
	logic                     have_best_q;
	logic                     ret_inst_q;
	logic [TS_W-1:0]          bkt_s_q;
	logic [TS_W-1:0]          bkt_e_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [VAL_W-1:0]  min_q;
	logic signed [VAL_W-1:0]  max_q;
	logic                     have_q;
	iosa_pkg::out_rsp_t       res_q;

	logic                    in_acc;
	logic                    out_acc;
	logic                    st_we;
	logic [IW-1:0]           rd_idx;
	logic [TS_W-1:0]         rd_start;
	logic [TS_W-1:0]         rd_end;
	logic [VAL_W:0]          rd_val;
	logic                    ev_end;
	logic [EW-1:0]           ev_id;
	logic [IW-1:0]           ev_idx;
	logic [KW-1:0]           cand_key;
	logic                    take;
	logic [KW-1:0]           best_nx;
	logic                    hb_nx;
	logic                    scan_last;
	logic                    agg_last;
	logic [TS_W-1:0]         cur_time;
	logic                    cur_end;
	logic [IW-1:0]           cur_id;
	logic [TS_W-1:0]         next_time;
	logic signed [VAL_W-1:0] rv;
	logic                    use_v;
	logic signed [SUM_W-1:0] sum_nx;
	logic                    div_start;
	logic                    div_done;
	logic signed [SUM_W-1:0] div_q;
	logic                    room;
	iosa_pkg::out_rsp_t      marker;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = (state_q == S_OUT) || (state_q == S_DONE);
	assign out_acc   = out_valid && !out_stall;
	assign out_rsp   = res_q;

	assign st_we = in_acc && (in_req.cmd == iosa_pkg::CMD_LOAD) &&
		(nload_q < CW'(MAX_INTERVALS));

	// event k: starts first (ids 0..N-1), then ends
	assign ev_end = k_q >= {1'b0, nload_q};
	assign ev_id  = ev_end ? k_q - {1'b0, nload_q} : k_q;
	assign ev_idx = ev_id[IW-1:0];
	assign rd_idx = (state_q == S_AGG) ? a_q : ev_idx;

	iosa_store #(.DEPTH(MAX_INTERVALS), .IW(IW)) u_store (
		.clk    (clk),
		.we     (st_we),
		.widx   (nload_q[IW-1:0]),
		.wstart (in_req.interval_start),
		.wend   (in_req.interval_end),
		.wval   ({in_req.value_present, in_req.interval_value}),
		.ridx   (rd_idx),
		.rstart (rd_start),
		.rend   (rd_end),
		.rval   (rd_val)
	);

	// sort key: time, starts before ends, starts by id up, ends by id down
	assign cand_key = {ev_end ? rd_end : rd_start, ev_end, ev_end ? ~ev_idx : ev_idx};
	assign take     = (!have_cur_q || cand_key > cur_key_q) &&
		(!have_best_q || cand_key < best_key_q);
	assign best_nx  = take ? cand_key : best_key_q;
	assign hb_nx    = take || have_best_q;
	assign scan_last = k_q == ({1'b0, nload_q} << 1) - EW'(1);
	assign agg_last  = EW'(a_q) == ({1'b0, nload_q} - EW'(1));

	assign cur_time  = cur_key_q[KW-1 -: TS_W];
	assign cur_end   = cur_key_q[IW];
	assign cur_id    = cur_end ? ~cur_key_q[IW-1:0] : cur_key_q[IW-1:0];
	assign next_time = best_key_q[KW-1 -: TS_W];
	assign room      = nres_q < RW'(RES_LIMIT - 1);

	assign rv     = $signed(rd_val[VAL_W-1:0]);
	assign use_v  = active_q[a_q] && rd_val[VAL_W];
	assign sum_nx = use_v ? sum_q + SUM_W'(rv) : sum_q;
	assign div_start = (state_q == S_AGG) && agg_last;

	iosa_div #(.DW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_nx),
		.divisor  (cnt_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_comb begin
		marker = '0;
		marker.load_overflow = ovf_q;
		marker.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			en_q        <= 1'b1;
			nload_q     <= '0;
			ovf_q       <= 1'b0;
			active_q    <= '0;
			cnt_q       <= '0;
			prev_q      <= '0;
			grp_q       <= '0;
			inst_q      <= 1'b0;
			nres_q      <= '0;
			k_q         <= '0;
			a_q         <= '0;
			have_cur_q  <= 1'b0;
			have_best_q <= 1'b0;
			ret_inst_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				en_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (in_req.cmd == iosa_pkg::CMD_LOAD) begin
							if (st_we) nload_q <= nload_q + 1'b1;
							else ovf_q <= 1'b1;
						end else if (nload_q == '0) begin
							res_q   <= marker;
							state_q <= S_DONE;
						end else begin
							k_q         <= '0;
							have_cur_q  <= 1'b0;
							have_best_q <= 1'b0;
							grp_q       <= '0;
							cnt_q       <= '0;
							active_q    <= '0;
							nres_q      <= '0;
							inst_q      <= 1'b0;
							state_q     <= S_FIND;
						end
					end
				end
				S_FIND: begin
					if (!scan_last) begin
						k_q         <= k_q + 1'b1;
						best_key_q  <= best_nx;
						have_best_q <= hb_nx;
					end else if (!have_cur_q) begin
						// first event seeds the sweep time
						cur_key_q   <= best_nx;
						have_cur_q  <= 1'b1;
						prev_q      <= best_nx[KW-1 -: TS_W];
						have_best_q <= 1'b0;
						k_q         <= '0;
					end else begin
						best_key_q  <= best_nx;
						have_best_q <= hb_nx;
						state_q     <= S_GAP;
					end
				end
				S_GAP: begin
					if (cur_time > prev_q) begin
						prev_q <= cur_time;
						inst_q <= 1'b0;
						if (cnt_q != '0 && room) begin
							bkt_s_q    <= prev_q;
							bkt_e_q    <= cur_time;
							ret_inst_q <= 1'b0;
							a_q        <= '0;
							sum_q      <= '0;
							have_q     <= 1'b0;
							state_q    <= S_AGG;
						end else begin
							grp_q   <= grp_q + 1'b1;
							state_q <= S_UPD;
						end
					end else begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!cur_end && !active_q[cur_id]) begin
						active_q[cur_id] <= 1'b1;
						cnt_q <= cnt_q + 1'b1;
					end else if (cur_end && active_q[cur_id]) begin
						active_q[cur_id] <= 1'b0;
						cnt_q <= cnt_q - 1'b1;
					end
					state_q <= S_INST;
				end
				S_INST: begin
					if (cur_end && !inst_q && cnt_q != '0 && have_best_q &&
						next_time == cur_time) begin
						inst_q <= 1'b1;
						if (room) begin
							bkt_s_q    <= cur_time;
							bkt_e_q    <= cur_time;
							ret_inst_q <= 1'b1;
							a_q        <= '0;
							sum_q      <= '0;
							have_q     <= 1'b0;
							state_q    <= S_AGG;
						end else begin
							grp_q   <= grp_q + 1'b1;
							state_q <= S_NEXT;
						end
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_AGG: begin
					sum_q <= sum_nx;
					if (use_v) begin
						if (!have_q || rv < min_q) min_q <= rv;
						if (!have_q || rv > max_q) max_q <= rv;
						have_q <= 1'b1;
					end
					a_q <= a_q + 1'b1;
					if (agg_last) state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						res_q.bucket_valid  <= 1'b1;
						res_q.bucket_start  <= bkt_s_q;
						res_q.bucket_end    <= bkt_e_q;
						res_q.group_number  <= grp_q;
						res_q.live_count    <= iosa_pkg::ACT_W'(cnt_q);
						res_q.value_sum     <= en_q ? sum_q : '0;
						res_q.value_min     <= (en_q && have_q) ? min_q : '0;
						res_q.value_max     <= (en_q && have_q) ? max_q : '0;
						res_q.min_max_valid <= en_q && have_q;
						res_q.value_average <= en_q ? div_q[VAL_W-1:0] : '0;
						res_q.load_overflow <= 1'b0;
						res_q.last          <= 1'b0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						nres_q  <= nres_q + 1'b1;
						grp_q   <= grp_q + 1'b1;
						state_q <= ret_inst_q ? S_NEXT : S_UPD;
					end
				end
				S_NEXT: begin
					if (have_best_q) begin
						cur_key_q   <= best_key_q;
						have_best_q <= 1'b0;
						k_q         <= '0;
						state_q     <= S_FIND;
					end else begin
						res_q   <= marker;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_acc) begin
						nload_q    <= '0;
						ovf_q      <= 1'b0;
						active_q   <= '0;
						have_cur_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/iosa_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosa_store
// Interval register file: one write port, one read port at a chosen index.
// ----------------------------------------------------------------------------
module iosa_store #(
	parameter int DEPTH = 16,
	parameter int IW    = 4
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [IW-1:0]                   widx,
	input  logic [iosa_pkg::TS_W-1:0]       wstart,
	input  logic [iosa_pkg::TS_W-1:0]       wend,
	input  logic [iosa_pkg::VAL_W:0]        wval,
	input  logic [IW-1:0]                   ridx,
	output logic [iosa_pkg::TS_W-1:0]       rstart,
	output logic [iosa_pkg::TS_W-1:0]       rend,
	output logic [iosa_pkg::VAL_W:0]        rval
);

	logic [iosa_pkg::TS_W-1:0] start_q [DEPTH];
	logic [iosa_pkg::TS_W-1:0] end_q   [DEPTH];
	logic [iosa_pkg::VAL_W:0]  val_q   [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			start_q[widx] <= wstart;
			end_q[widx]   <= wend;
			val_q[widx]   <= wval;
		end
	end

	assign rstart = start_q[ridx];
	assign rend   = end_q[ridx];
	assign rval   = val_q[ridx];

endmodule

// ===== src/iosa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosa_div
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module iosa_div #(
	parameter int DW = 5
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [iosa_pkg::SUM_W-1:0]  dividend,
	input  logic [DW-1:0]                      divisor,
	output logic                               done,
	output logic signed [iosa_pkg::SUM_W-1:0]  quotient
);

	localparam int NW = iosa_pkg::SUM_W;
	localparam int IT = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [IT-1:0] it_q;
	logic          neg_q;
	logic [NW-1:0] q_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   sh;
	logic          ge;
	logic [DW:0]   diff;
	logic          final_it;

	assign sh   = {rem_q, q_q[NW-1]};
	assign ge   = sh >= {1'b0, dvs_q};
	assign diff = sh - {1'b0, dvs_q};
	assign final_it = it_q == IT'(NW - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			it_q   <= '0;
		end else begin
			done_q <= !start && busy_q && final_it;
			if (start) begin
				busy_q <= 1'b1;
				it_q   <= '0;
				neg_q  <= dividend[NW-1];
				q_q    <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
				rem_q  <= '0;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
				q_q   <= {q_q[NW-2:0], ge};
				it_q  <= it_q + 1'b1;
				if (final_it) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(q_q) : $signed(q_q);

endmodule

// ===== src/iosa_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iosa_chk
// Port-level checks for the interval overlap sweep aggregator.
// ----------------------------------------------------------------------------
`include "interval_overlap_sweep_aggregator_assert.svh"

module iosa_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input iosa_pkg::in_req_t  in_req,
	input logic               out_valid,
	input logic               out_stall,
	input iosa_pkg::out_rsp_t out_rsp,
	input logic               cfg_we,
	input logic               cfg_wdata
);

	logic out_wait;
	logic sweep_acc;
	logic is_marker;
	logic is_bucket;
	logic bucket_ok;

	assign out_wait  = out_valid && out_stall;
	assign sweep_acc = in_valid && !in_stall && (in_req.cmd == iosa_pkg::CMD_SWEEP);
	assign is_marker = out_valid && !out_rsp.bucket_valid;
	assign is_bucket = out_valid && out_rsp.bucket_valid;
	assign bucket_ok = (out_rsp.live_count != '0) &&
		(out_rsp.bucket_start <= out_rsp.bucket_end) && !out_rsp.last;

	`IOSA_ASSERT_NXT(a_hold, out_wait, $stable(out_rsp), "result changed while stalled")
	`IOSA_ASSERT_NXT(a_sweep_busy, sweep_acc, in_stall, "sweep request not busy")
	`IOSA_ASSERT_NOW(a_marker, is_marker, out_rsp.last, "marker without last")
	`IOSA_ASSERT_NOW(a_bucket, is_bucket, bucket_ok, "bad bucket")
	`IOSA_ASSERT_NOW(a_out_busy, out_valid, in_stall, "request taken while result pending")

endmodule

bind interval_overlap_sweep_aggregator iosa_chk u_iosa_chk (.*);
